FILE: design/nvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvp_pkg
// Shared types and constants for the name-value pair stream parser.
// ----------------------------------------------------------------------------
package nvp_pkg;

    localparam int unsigned LEN_W = 31;

    localparam logic [7:0] LONG_LEN_FLAG  = 8'h80;
    localparam logic [1:0] LONG_LEN_BYTES = 2'd3;  // extended bytes after the first

    localparam logic [1:0] KIND_LENGTH = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;

    typedef enum logic [5:0] {
        PH_NLEN0 = 6'b000001,
        PH_NLENX = 6'b000010,
        PH_VLEN0 = 6'b000100,
        PH_VLENX = 6'b001000,
        PH_NAME  = 6'b010000,
        PH_VALUE = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       content_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       pair_done;
        logic       content_done;
        logic       truncated;
    } t_out;

endpackage

FILE: design/nvp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvp_parse_core
// Parser state and the per-byte tagging logic. The result is combinational
// from the current state and the incoming byte; state advances on accept.
// ----------------------------------------------------------------------------
module nvp_parse_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  nvp_pkg::t_in i_data,
    output nvp_pkg::t_out o_result
);
    import nvp_pkg::*;

    t_phase             r_phase,      n_phase;
    logic [1:0]         r_len_left,   n_len_left;
    logic [LEN_W-1:0]   r_len_acc,    n_len_acc;
    logic [LEN_W-1:0]   r_name_left,  n_name_left;
    logic [LEN_W-1:0]   r_value_left, n_value_left;

    logic [7:0]       b;
    logic [1:0]       kind;
    logic             done;
    logic             trunc;
    logic [LEN_W-1:0] acc_shift;
    logic [LEN_W-1:0] name_dec;
    logic [LEN_W-1:0] value_dec;

    assign b         = i_data.data_byte;
    assign acc_shift = {r_len_acc[LEN_W-9:0], b};
    assign name_dec  = r_name_left - LEN_W'(1);
    assign value_dec = r_value_left - LEN_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_len_left   = r_len_left;
        n_len_acc    = r_len_acc;
        n_name_left  = r_name_left;
        n_value_left = r_value_left;
        kind         = KIND_LENGTH;
        done         = 1'b0;

        case (r_phase)
            PH_NLENX, PH_VLENX: begin
                n_len_acc  = acc_shift;
                n_len_left = r_len_left - 2'd1;
                if (n_len_left == 2'd0) begin
                    if (r_phase == PH_NLENX) begin
                        n_name_left = acc_shift;
                        n_phase     = PH_VLEN0;
                    end else begin
                        n_value_left = acc_shift;
                        if (r_name_left != '0) begin
                            n_phase = PH_NAME;
                        end else if (acc_shift != '0) begin
                            n_phase = PH_VALUE;
                        end else begin
                            n_phase = PH_NLEN0;
                            done    = 1'b1;
                        end
                    end
                end
            end
            PH_VLEN0: begin
                if ((b & LONG_LEN_FLAG) != 8'd0) begin
                    n_len_acc  = LEN_W'(b[6:0]);
                    n_len_left = LONG_LEN_BYTES;
                    n_phase    = PH_VLENX;
                end else begin
                    n_value_left = LEN_W'(b);
                    if (r_name_left != '0) begin
                        n_phase = PH_NAME;
                    end else if (b != 8'd0) begin
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase = PH_NLEN0;
                        done    = 1'b1;
                    end
                end
            end
            PH_NAME: begin
                kind        = KIND_NAME;
                n_name_left = name_dec;
                if (name_dec == '0) begin
                    if (r_value_left != '0) begin
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase = PH_NLEN0;
                        done    = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                kind         = KIND_VALUE;
                n_value_left = value_dec;
                if (value_dec == '0) begin
                    n_phase = PH_NLEN0;
                    done    = 1'b1;
                end
            end
            default: begin
                if ((b & LONG_LEN_FLAG) != 8'd0) begin
                    n_len_acc  = LEN_W'(b[6:0]);
                    n_len_left = LONG_LEN_BYTES;
                    n_phase    = PH_NLENX;
                end else begin
                    n_name_left = LEN_W'(b);
                    n_phase     = PH_VLEN0;
                end
            end
        endcase

        trunc = i_data.content_end && (n_phase != PH_NLEN0);

        // The final byte of a content always leaves the parser ready for a new one.
        if (i_data.content_end) begin
            n_phase      = PH_NLEN0;
            n_len_left   = 2'd0;
            n_len_acc    = '0;
            n_name_left  = '0;
            n_value_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NLEN0;
            r_len_left   <= 2'd0;
            r_len_acc    <= '0;
            r_name_left  <= '0;
            r_value_left <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_len_left   <= n_len_left;
            r_len_acc    <= n_len_acc;
            r_name_left  <= n_name_left;
            r_value_left <= n_value_left;
        end
    end

    assign o_result.out_byte     = b;
    assign o_result.byte_kind    = kind;
    assign o_result.pair_done    = done;
    assign o_result.content_done = i_data.content_end;
    assign o_result.truncated    = trunc;

endmodule

FILE: design/name_value_pair_stream_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_value_pair_stream_parser_unit
// Tags each byte of a FastCGI-style name-value content stream as a length,
// name or value byte, marks pair completion, and flags truncated content.
// ----------------------------------------------------------------------------
// The block takes one content byte per cycle while the skid register is
// empty, and returns exactly one tagged byte for each, in order. A new
// transaction can be accepted on every clock while input is not stalled; a
// two-entry output stage (result register plus skid register) lets input
// keep flowing until the skid register fills after the output side stalls.
// Input stall comes straight from the skid register. The state returns to
// the start of a pair after every byte marked as the end of content.
module name_value_pair_stream_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  nvp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nvp_pkg::t_out o_out_data
);
    import nvp_pkg::*;

    logic  accept;
    t_out  result;
    logic  r_out_valid;
    t_out  r_out_data;
    logic  r_skid_valid;
    t_out  r_skid_data;

    assign accept = i_in_valid && !r_skid_valid;

    nvp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end else if (accept) begin
            r_skid_data <= result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_trunc_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.truncated) |-> o_out_data.content_done)
        else $error("truncated flag raised on a byte that does not end the content");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.byte_kind != 2'd3))
        else $error("illegal byte kind");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.pair_done && o_out_data.truncated) |-> 1'b0)
        else $error("pair completed yet content reported truncated");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the name-value pair stream parser.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes runs first: empty pairs, name-only and
// value-only pairs, four-byte lengths and content cut short. Random contents
// follow, mostly well-formed pairs with a few cut or noisy ones. Every tagged
// byte is checked against an in-order byte tagger, while both handshakes
// idle at random and the output side holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import nvp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_BYTES = 600;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 60;
    localparam int N_DIR        = 25;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        logic [1:0] kind;
        logic       done;
        logic       trunc;
    } t_dir_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    name_value_pair_stream_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Byte tagger state, mirrored from the block's parse rules.
    t_phase      parse_state;
    logic [1:0]  ext_len_left;
    logic [30:0] ext_len_acc;
    logic [30:0] name_remaining;
    logic [30:0] value_remaining;

    t_out     tag_due_q [$];
    t_in      content_q [$];
    t_dir_row dir_rows [N_DIR];

    int snd_idle_pct = 29;
    int rcv_idle_pct = 46;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int cycle_count  = 0;
    int errors       = 0;
    int results_seen = 0;
    int pairs_seen   = 0;
    int contents_seen = 0;
    int trunc_seen   = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, tag_due_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void clear_parse();
        parse_state     = PH_NLEN0;
        ext_len_left    = '0;
        ext_len_acc     = '0;
        name_remaining  = '0;
        value_remaining = '0;
    endfunction

    // Both lengths are known: pick the body phase, or report that the pair
    // is already complete because name and value are both empty.
    function automatic logic start_body();
        if (name_remaining != '0) begin
            parse_state = PH_NAME;
        end else if (value_remaining != '0) begin
            parse_state = PH_VALUE;
        end else begin
            parse_state = PH_NLEN0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out predict_tag(input t_in item);
        t_out tag;
        tag              = '0;
        tag.out_byte     = item.data_byte;
        tag.byte_kind    = KIND_LENGTH;
        tag.content_done = item.content_end;
        case (parse_state)
            PH_NLENX, PH_VLENX: begin
                ext_len_acc  = {ext_len_acc[22:0], item.data_byte};
                ext_len_left = ext_len_left - 2'd1;
                if (ext_len_left == 2'd0) begin
                    if (parse_state == PH_NLENX) begin
                        name_remaining = ext_len_acc;
                        parse_state    = PH_VLEN0;
                    end else begin
                        value_remaining = ext_len_acc;
                        tag.pair_done   = start_body();
                    end
                end
            end
            PH_VLEN0: begin
                if ((item.data_byte & LONG_LEN_FLAG) != 8'h00) begin
                    ext_len_acc  = {24'd0, item.data_byte[6:0]};
                    ext_len_left = LONG_LEN_BYTES;
                    parse_state  = PH_VLENX;
                end else begin
                    value_remaining = {23'd0, item.data_byte};
                    tag.pair_done   = start_body();
                end
            end
            PH_NAME: begin
                tag.byte_kind  = KIND_NAME;
                name_remaining = name_remaining - 31'd1;
                if (name_remaining == '0) begin
                    if (value_remaining != '0) begin
                        parse_state = PH_VALUE;
                    end else begin
                        parse_state   = PH_NLEN0;
                        tag.pair_done = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                tag.byte_kind   = KIND_VALUE;
                value_remaining = value_remaining - 31'd1;
                if (value_remaining == '0) begin
                    parse_state   = PH_NLEN0;
                    tag.pair_done = 1'b1;
                end
            end
            default: begin
                if ((item.data_byte & LONG_LEN_FLAG) != 8'h00) begin
                    ext_len_acc  = {24'd0, item.data_byte[6:0]};
                    ext_len_left = LONG_LEN_BYTES;
                    parse_state  = PH_NLENX;
                end else begin
                    name_remaining = {23'd0, item.data_byte};
                    parse_state    = PH_VLEN0;
                end
            end
        endcase
        if (item.content_end) begin
            tag.truncated = (parse_state != PH_NLEN0);
            clear_parse();
        end
        return tag;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 20) begin
            $display("MISMATCH at result %0d: %s", results_seen, what);
        end
    endtask

    // One transaction per call; the tag it should produce is queued once the
    // byte is accepted.
    task automatic send_byte(input t_in item, input bit typed, input t_out typed_tag);
        t_out predicted;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_tag(item);
        tag_due_q.push_back(typed ? typed_tag : predicted);
    endtask

    // Always advances at least one cycle, so the next valid is never driven
    // twice in one time step.
    task automatic wait_all_tagged();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tag_due_q.size() != 0);
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_in item;
        item.data_byte   = b;
        item.content_end = 1'b0;
        content_q.push_back(item);
    endtask

    task automatic push_len(input logic [30:0] len, input bit long_form);
        if (long_form || len > 31'd127) begin
            push_byte({1'b1, len[30:24]});
            push_byte(len[23:16]);
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end else begin
            push_byte(len[7:0]);
        end
    endtask

    function automatic logic [30:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)   return '0;
        if (r < 16)  return 31'($urandom_range(1, 6));
        if (r < 19)  return 31'($urandom_range(7, 20));
        return 31'($urandom_range(100, 127));
    endfunction

    // Mostly well-formed contents of a few pairs; some are cut short, some
    // carry a huge four-byte length, and a few are plain noise.
    task automatic build_content();
        int          kind_pick;
        int          n_pairs;
        int          cut_at;
        logic [30:0] nlen;
        logic [30:0] vlen;
        kind_pick = $urandom_range(0, 39);
        if (kind_pick < 3) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        end else if (kind_pick < 5) begin
            push_len(31'($urandom), 1'b1);
            repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
        end else begin
            n_pairs = $urandom_range(1, 4);
            repeat (n_pairs) begin
                nlen = pick_len();
                vlen = pick_len();
                push_len(nlen, $urandom_range(0, 4) == 0);
                push_len(vlen, $urandom_range(0, 4) == 0);
                repeat (nlen) push_byte(8'($urandom_range(0, 255)));
                repeat (vlen) push_byte(8'($urandom_range(0, 255)));
            end
            if (kind_pick < 9 && content_q.size() > 1) begin
                cut_at = $urandom_range(0, content_q.size() - 2);
                while (content_q.size() > cut_at + 1) void'(content_q.pop_back());
            end
        end
        content_q[content_q.size() - 1].content_end = 1'b1;
    endtask

    // Output side: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            results_seen++;
            if (tag_due_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = tag_due_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              got.out_byte, want.out_byte));
                if (got.byte_kind !== want.byte_kind)
                    report_mismatch($sformatf("byte_kind %0d, want %0d",
                                              got.byte_kind, want.byte_kind));
                if (got.pair_done !== want.pair_done)
                    report_mismatch($sformatf("pair_done %b, want %b",
                                              got.pair_done, want.pair_done));
                if (got.content_done !== want.content_done)
                    report_mismatch($sformatf("content_done %b, want %b",
                                              got.content_done, want.content_done));
                if (got.truncated !== want.truncated)
                    report_mismatch($sformatf("truncated %b, want %b",
                                              got.truncated, want.truncated));
            end
            if (got.pair_done === 1'b1) pairs_seen++;
            if (got.content_done === 1'b1) contents_seen++;
            if (got.truncated === 1'b1) trunc_seen++;
        end
    end

    initial begin
        t_in  item;
        t_out typed_tag;
        int   bytes_sent;
        bit   paused;
        bit   held;
        clear_parse();
        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, KIND_LENGTH, 1'b0, 1'b0},  // name length 0
            '{8'h00, 1'b0, 1'b1, KIND_LENGTH, 1'b1, 1'b0},  // empty pair
            '{8'h01, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'hFF, 1'b0, 1'b1, KIND_NAME,   1'b1, 1'b0},  // name-only pair
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h02, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},  // value-only pair
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'hA5, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},  // four-byte name length
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h01, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},  // four-byte value length
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h02, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h7F, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h5A, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'hFF, 1'b1, 1'b1, KIND_LENGTH, 1'b0, 1'b1},  // ends inside a length
            '{8'h7F, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, KIND_LENGTH, 1'b0, 1'b1},  // ends before the name
            '{8'h00, 1'b0, 1'b0, KIND_LENGTH, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, KIND_LENGTH, 1'b1, 1'b0}   // clean end on empty pair
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            item.data_byte          = dir_rows[i].b;
            item.content_end        = dir_rows[i].last;
            typed_tag.out_byte      = dir_rows[i].b;
            typed_tag.byte_kind     = dir_rows[i].kind;
            typed_tag.pair_done     = dir_rows[i].done;
            typed_tag.content_done  = dir_rows[i].last;
            typed_tag.truncated     = dir_rows[i].trunc;
            send_byte(item, dir_rows[i].typed, typed_tag);
        end
        wait_all_tagged();

        bytes_sent = 0;
        paused     = 1'b0;
        held       = 1'b0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent < RANDOM_BYTES / 3) begin
                snd_idle_pct = 29;
                rcv_idle_pct = 46;
            end else if (bytes_sent < 2 * RANDOM_BYTES / 3) begin
                snd_idle_pct = 46;
                rcv_idle_pct = 29;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // With no idling on either side, a long output hold-off makes
            // the block fill up and stall its input.
            if (!held && bytes_sent >= 3 * RANDOM_BYTES / 4) begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            build_content();
            while (content_q.size() != 0) begin
                send_byte(content_q.pop_front(), 1'b0, '0);
                bytes_sent++;
            end
            if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
                wait_all_tagged();
                paused = 1'b1;
            end
        end

        wait_all_tagged();
        repeat (8) @(posedge i_clk);
        if (tag_due_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", tag_due_q.size()));
        end

        $display("Checked %0d tagged bytes over %0d contents: %0d pairs completed,",
                 results_seen, contents_seen, pairs_seen);
        $display("%0d contents cut short, %0d mismatches.", trunc_seen, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/nvp_pkg.sv
design/nvp_parse_core.sv
design/name_value_pair_stream_parser_unit.sv
tb/tb.sv
